[hw/rtl/descending_selection_sort_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the descending selection sort unit
// Shared property forms, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef DESCENDING_SELECTION_SORT_UNIT_ASSERT_SVH
`define DESCENDING_SELECTION_SORT_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define DSS_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DSS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hw/rtl/dss_pkg.sv]
// ----------------------------------------------------------------------------
// Descending selection sort package
// Capacity, widths, request, result and entry types and the sequencer states.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic signed [31:0] entry_score;
        logic [31:0]        entry_payload;
        logic               last_entry;
    } request_t;

    typedef struct packed {
        logic signed [31:0] sorted_score;
        logic [31:0]        sorted_payload;
        logic               final_result;
        logic               overflowed;
    } result_t;

    // One stored entry: key and payload side by side in a single memory word.
    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        payload;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWAP_FRONT,
        ST_SWAP_BEST,
        ST_EMIT
    } state_t;

endpackage

[hw/rtl/descending_selection_sort_unit.sv]
// ----------------------------------------------------------------------------
// Descending selection sort unit
// Collects a list of scored entries, sorts it largest score first by
// selection sort in a single entry memory, then streams the sorted list out.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload              Direction
//  -------   -------------------------  -------------------  ---------
//  request   start, taken when !busy    request (request_t)  in
//  result    result_valid, one cycle    result (result_t)    out
//
// Each request is stored as it is taken. A request flagged as last closes the
// list; for n stored entries the unit then stays busy while it sorts, and
// after that while the n results appear on consecutive cycles. The sorting
// time is set by the single read port of the entry memory: the scan reads
// one entry per cycle and each swap needs two writes on the single write port.
// Reset clears the sequencer, the entry count, the overflow flag, the index
// registers and the read-pending flag; the memory needs no clearing because
// only written entries are ever read.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module descending_selection_sort_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dss_pkg::request_t  request,
    output logic               result_valid,
    output dss_pkg::result_t   result
);

    // Entry memory: key and payload of each list position.
    dss_pkg::entry_t mem [dss_pkg::MAX_ENTRIES];

    logic                       mem_we;
    logic [dss_pkg::IDX_W-1:0]  mem_waddr;
    dss_pkg::entry_t            mem_wdata;
    logic                       mem_re;
    logic [dss_pkg::IDX_W-1:0]  mem_raddr;
    dss_pkg::entry_t            rd_data_reg;

    dss_pkg::state_t            state_reg, state_next;
    logic [dss_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       ovf_reg, ovf_next;
    logic [dss_pkg::IDX_W-1:0]  front_reg, front_next;
    logic [dss_pkg::CNT_W-1:0]  issue_reg, issue_next;
    logic                       rd_pend_reg, rd_pend_next;
    logic [dss_pkg::IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    dss_pkg::entry_t            best_reg, best_next;
    logic [dss_pkg::IDX_W-1:0]  best_idx_reg, best_idx_next;
    dss_pkg::entry_t            front_ent_reg, front_ent_next;

    // Index of the last stored entry; only meaningful while a list is held.
    logic [dss_pkg::IDX_W-1:0]  last_idx;
    logic                       last_read;
    logic [dss_pkg::CNT_W-1:0]  count_loaded;

    assign last_idx  = dss_pkg::IDX_W'(count_reg - dss_pkg::CNT_W'(1));
    assign last_read = rd_pend_reg && (rd_idx_reg == last_idx);

    // The memory is written and read in one clocked block; reads are
    // registered, so data for an address issued now arrives next cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dss_pkg::ST_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            front_reg    <= '0;
            issue_reg    <= '0;
            rd_pend_reg  <= 1'b0;
            rd_idx_reg   <= '0;
            best_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            front_reg    <= front_next;
            issue_reg    <= issue_next;
            rd_pend_reg  <= rd_pend_next;
            rd_idx_reg   <= rd_idx_next;
            best_idx_reg <= best_idx_next;
        end
    end

    // Entry holding registers carry data only and need no reset.
    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        front_ent_reg <= front_ent_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        front_next     = front_reg;
        issue_next     = issue_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        front_ent_next = front_ent_reg;
        count_loaded   = count_reg;

        mem_we    = 1'b0;
        mem_waddr = count_reg[dss_pkg::IDX_W-1:0];
        mem_wdata = best_reg;
        mem_re    = 1'b0;
        mem_raddr = issue_reg[dss_pkg::IDX_W-1:0];

        busy         = (state_reg != dss_pkg::ST_IDLE);
        result_valid = 1'b0;

        // While scanning or emitting, one read is issued per cycle until the
        // last stored entry has been requested from the memory.
        if ((state_reg == dss_pkg::ST_SCAN || state_reg == dss_pkg::ST_EMIT) &&
            (issue_reg < count_reg))
        begin
            mem_re       = 1'b1;
            issue_next   = issue_reg + dss_pkg::CNT_W'(1);
            rd_pend_next = 1'b1;
            rd_idx_next  = issue_reg[dss_pkg::IDX_W-1:0];
        end

        case (state_reg)
            dss_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // A full store drops the entry and records the overflow.
                    if (count_reg < dss_pkg::CNT_W'(dss_pkg::MAX_ENTRIES))
                    begin
                        mem_we       = 1'b1;
                        mem_wdata    = '{key: request.entry_score,
                                         payload: request.entry_payload};
                        count_loaded = count_reg + dss_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    count_next = count_loaded;

                    if (request.last_entry)
                    begin
                        front_next = '0;
                        issue_next = '0;
                        // A single entry is already in order.
                        if (count_loaded == dss_pkg::CNT_W'(1))
                        begin
                            state_next = dss_pkg::ST_EMIT;
                        end
                        else
                        begin
                            state_next = dss_pkg::ST_SCAN;
                        end
                    end
                end
            end

            dss_pkg::ST_SCAN:
            begin
                if (rd_pend_reg)
                begin
                    if (rd_idx_reg == front_reg)
                    begin
                        // The front entry seeds the running maximum.
                        best_next      = rd_data_reg;
                        best_idx_next  = front_reg;
                        front_ent_next = rd_data_reg;
                    end
                    else if ($signed(rd_data_reg.key) > $signed(best_reg.key))
                    begin
                        // Strictly greater only, so the first of equal keys wins.
                        best_next     = rd_data_reg;
                        best_idx_next = rd_idx_reg;
                    end
                    if (last_read)
                    begin
                        state_next = dss_pkg::ST_SWAP_FRONT;
                    end
                end
            end

            dss_pkg::ST_SWAP_FRONT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = front_reg;
                mem_wdata  = best_reg;
                state_next = dss_pkg::ST_SWAP_BEST;
            end

            dss_pkg::ST_SWAP_BEST:
            begin
                mem_we     = 1'b1;
                mem_waddr  = best_idx_reg;
                mem_wdata  = front_ent_reg;
                front_next = front_reg + dss_pkg::IDX_W'(1);
                if ((dss_pkg::CNT_W'(front_reg) + dss_pkg::CNT_W'(2)) < count_reg)
                begin
                    issue_next = dss_pkg::CNT_W'(front_reg) + dss_pkg::CNT_W'(1);
                    state_next = dss_pkg::ST_SCAN;
                end
                else
                begin
                    issue_next = '0;
                    state_next = dss_pkg::ST_EMIT;
                end
            end

            dss_pkg::ST_EMIT:
            begin
                if (rd_pend_reg)
                begin
                    result_valid = 1'b1;
                    if (last_read)
                    begin
                        // The list is finished: ready for the next one.
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = dss_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = dss_pkg::ST_IDLE;
            end
        endcase
    end

    assign result.sorted_score   = rd_data_reg.key;
    assign result.sorted_payload = rd_data_reg.payload;
    assign result.final_result   = last_read;
    assign result.overflowed     = ovf_reg;

endmodule

[hw/rtl/dss_checker.sv]
// ----------------------------------------------------------------------------
// Descending selection sort checker
// Watches the ports of the sort unit for sequencing errors over time.
// ----------------------------------------------------------------------------
`include "descending_selection_sort_unit_assert.svh"

module dss_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input dss_pkg::request_t request,
    input logic              result_valid,
    input dss_pkg::result_t  result
);

    `DSS_ASSERT_SAME(a_result_while_busy, result_valid, busy, "result outside a busy period")
    `DSS_ASSERT_NEXT(a_last_starts_sort, start && !busy && request.last_entry, busy, "closing request did not start sorting")
    `DSS_ASSERT_NEXT(a_plain_load_idle, start && !busy && !request.last_entry, !busy, "loading a request made the unit busy")
    `DSS_ASSERT_NEXT(a_results_contiguous, result_valid && !result.final_result, result_valid, "gap in the sorted result stream")
    `DSS_ASSERT_NEXT(a_final_frees_unit, result_valid && result.final_result, !busy, "unit still busy after the final result")

endmodule

bind descending_selection_sort_unit dss_checker u_dss_checker (.*);
